[design/ccst_pkg.sv]
// ----------------------------------------------------------------------------
// ccst_pkg
// Shared types and constants for the client capability slot table.
// ----------------------------------------------------------------------------
package ccst_pkg;

    // request operation codes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    // fixed field widths
    localparam int BADGE_W = 32;
    localparam int CAP_W   = 32;
    localparam int MOUNT_W = 4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_SEARCH,
        S_REPORT
    } t_state;

endpackage

[design/client_capability_slot_table_core.sv]
// ----------------------------------------------------------------------------
// client_capability_slot_table_core
// Maps a client badge and a capability to a slot. Set appends the capability
// to the client's row (creating the row if needed); get returns the lowest
// slot that holds the capability.
// ----------------------------------------------------------------------------
// A request walks the rows (S_SCAN) and executes (S_EXEC); a get from a known
// client with a filled row then searches its slots (S_SEARCH) before the
// result is reported (S_REPORT). One item at a time: the next request is
// taken once the result is registered, later if the previous result is still
// waiting. Walk and search read one entry a cycle.
// Reset (i_rst_n low, synchronous) clears row valid marks and control state.
module client_capability_slot_table_core
    import ccst_pkg::*;
#(
    parameter int MAX_CLIENTS      = 8,
    parameter int SLOTS_PER_CLIENT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic                      i_operation,
    input  logic [BADGE_W-1:0]        i_client_badge,
    input  logic signed [CAP_W-1:0]   i_cap_value,
    // result channel
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output logic                      o_success,
    output logic [MOUNT_W-1:0]        o_mount_slot
);

    localparam int RW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam int FW = $clog2(SLOTS_PER_CLIENT + 1);
    localparam int DEPTH = MAX_CLIENTS * SLOTS_PER_CLIENT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = BADGE_W + FW;

    // control and request registers
    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [BADGE_W-1:0] r_badge, n_badge;
    logic [CAP_W-1:0]   r_cap, n_cap;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [RW-1:0]      r_chk_row, n_chk_row;
    logic [FW-1:0]      r_chk_slot, n_chk_slot;
    logic               r_hit, n_hit;
    logic [RW-1:0]      r_hit_row, n_hit_row;
    logic [FW-1:0]      r_hit_fill, n_hit_fill;
    logic               r_free, n_free;
    logic [RW-1:0]      r_free_row, n_free_row;
    logic [AW-1:0]      r_base, n_base;
    logic [FW-1:0]      r_j, n_j;
    logic               r_res_ok, n_res_ok;
    logic [FW-1:0]      r_res_slot, n_res_slot;
    logic               r_rsp_valid, n_rsp_valid;
    logic               r_success, n_success;
    logic [MOUNT_W-1:0] r_mount, n_mount;
    logic [MAX_CLIENTS-1:0] r_row_valid, n_row_valid;

    // memories: row metadata {badge, fill} and capability slots
    logic [MW-1:0]    r_meta_mem [MAX_CLIENTS];
    logic [CAP_W-1:0] r_cap_mem  [DEPTH];
    logic [MW-1:0]    r_meta_q;
    logic [CAP_W-1:0] r_cap_q;

    logic               meta_we;
    logic [RW-1:0]      meta_waddr;
    logic [MW-1:0]      meta_wdata;
    logic [RW-1:0]      meta_raddr;
    logic               cap_we;
    logic [AW-1:0]      cap_waddr;
    logic [AW-1:0]      cap_raddr;

    logic               req_fire;
    logic               out_free;
    logic               scan_last;
    logic               srch_hit;
    logic               srch_end;
    logic               get_go;
    logic [BADGE_W-1:0] q_badge;
    logic [FW-1:0]      q_fill;
    logic [AW-1:0]      hit_base;
    logic [AW-1:0]      free_base;
    logic [FW+MOUNT_W-1:0] slot_ext;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire  = i_req_valid && o_req_ready;
    assign out_free  = !r_rsp_valid || i_rsp_ready;
    assign scan_last = (r_idx == CW'(MAX_CLIENTS));
    assign srch_hit  = r_chk_vld && (r_cap_q == r_cap);
    assign srch_end  = (r_j == r_hit_fill) && !srch_hit;
    assign get_go    = r_hit && (r_hit_fill != '0);
    assign q_badge   = r_meta_q[MW-1:FW];
    assign q_fill    = r_meta_q[FW-1:0];
    assign hit_base  = AW'(AW'(r_hit_row) * AW'(SLOTS_PER_CLIENT));
    assign free_base = AW'(AW'(r_free_row) * AW'(SLOTS_PER_CLIENT));
    assign slot_ext  = {{MOUNT_W{1'b0}}, r_res_slot};

    // memory ports
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= r_meta_mem[meta_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            r_cap_mem[cap_waddr] <= r_cap;
        end
        r_cap_q <= r_cap_mem[cap_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_GET && get_go) n_state = S_SEARCH;
                else n_state = S_REPORT;
            end
            S_SEARCH: begin
                if (srch_hit || srch_end) n_state = S_REPORT;
            end
            S_REPORT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op        = r_op;
        n_badge     = r_badge;
        n_cap       = r_cap;
        n_idx       = r_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_row   = r_chk_row;
        n_chk_slot  = r_chk_slot;
        n_hit       = r_hit;
        n_hit_row   = r_hit_row;
        n_hit_fill  = r_hit_fill;
        n_free      = r_free;
        n_free_row  = r_free_row;
        n_base      = r_base;
        n_j         = r_j;
        n_res_ok    = r_res_ok;
        n_res_slot  = r_res_slot;
        n_row_valid = r_row_valid;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_success   = r_success;
        n_mount     = r_mount;
        meta_we     = 1'b0;
        meta_waddr  = r_hit_row;
        meta_wdata  = {r_badge, r_hit_fill};
        meta_raddr  = r_idx[RW-1:0];
        cap_we      = 1'b0;
        cap_waddr   = hit_base;
        cap_raddr   = AW'(r_base + AW'(r_j));

        case (r_state)
            // latch the request
            S_IDLE: begin
                if (req_fire) begin
                    n_op      = i_operation;
                    n_badge   = i_client_badge;
                    n_cap     = $unsigned(i_cap_value);
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                end
            end
            // walk the rows: read one, check the one read last cycle
            S_SCAN: begin
                if (!scan_last) begin
                    n_idx     = CW'(r_idx + 1'b1);
                    n_chk_vld = 1'b1;
                    n_chk_row = r_idx[RW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    if (r_row_valid[r_chk_row] && q_badge == r_badge && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_row  = r_chk_row;
                        n_hit_fill = q_fill;
                    end
                    if (!r_row_valid[r_chk_row] && !r_free) begin
                        n_free     = 1'b1;
                        n_free_row = r_chk_row;
                    end
                end
            end
            // append on set, start the slot search on get
            S_EXEC: begin
                n_res_ok   = 1'b0;
                n_res_slot = '0;
                if (r_op == OP_SET) begin
                    if (r_hit) begin
                        if (r_hit_fill < FW'(SLOTS_PER_CLIENT)) begin
                            cap_we     = 1'b1;
                            cap_waddr  = AW'(hit_base + AW'(r_hit_fill));
                            meta_we    = 1'b1;
                            meta_waddr = r_hit_row;
                            meta_wdata = {r_badge, FW'(r_hit_fill + 1'b1)};
                            n_res_ok   = 1'b1;
                            n_res_slot = r_hit_fill;
                        end
                    end else if (r_free) begin
                        cap_we      = 1'b1;
                        cap_waddr   = free_base;
                        meta_we     = 1'b1;
                        meta_waddr  = r_free_row;
                        meta_wdata  = {r_badge, FW'(1)};
                        n_row_valid[r_free_row] = 1'b1;
                        n_res_ok    = 1'b1;
                    end
                end else if (get_go) begin
                    n_base    = hit_base;
                    n_j       = '0;
                    n_chk_vld = 1'b0;
                end
            end
            // read one slot a cycle, compare the one read last cycle
            S_SEARCH: begin
                if (r_j != r_hit_fill) begin
                    n_j        = FW'(r_j + 1'b1);
                    n_chk_vld  = 1'b1;
                    n_chk_slot = r_j;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (srch_hit) begin
                    n_res_ok   = 1'b1;
                    n_res_slot = r_chk_slot;
                end
            end
            // hand the result to the output register
            S_REPORT: begin
                if (out_free) begin
                    n_rsp_valid = 1'b1;
                    n_success   = r_res_ok;
                    n_mount     = r_res_ok ? slot_ext[MOUNT_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_rsp_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_rsp_valid <= n_rsp_valid;
            r_chk_vld   <= n_chk_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_badge    <= n_badge;
        r_cap      <= n_cap;
        r_idx      <= n_idx;
        r_chk_row  <= n_chk_row;
        r_chk_slot <= n_chk_slot;
        r_hit      <= n_hit;
        r_hit_row  <= n_hit_row;
        r_hit_fill <= n_hit_fill;
        r_free     <= n_free;
        r_free_row <= n_free_row;
        r_base     <= n_base;
        r_j        <= n_j;
        r_res_ok   <= n_res_ok;
        r_res_slot <= n_res_slot;
        r_success  <= n_success;
        r_mount    <= n_mount;
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_success    = r_success;
    assign o_mount_slot = r_mount;

endmodule

[design/ccst_checker.sv]
// ----------------------------------------------------------------------------
// ccst_checker
// Port-level checks for the client capability slot table, bound to the top.
// ----------------------------------------------------------------------------
module ccst_checker
    import ccst_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    o_req_ready,
    input logic                    i_operation,
    input logic [BADGE_W-1:0]      i_client_badge,
    input logic signed [CAP_W-1:0] i_cap_value,
    input logic                    o_rsp_valid,
    input logic                    i_rsp_ready,
    input logic                    o_success,
    input logic [MOUNT_W-1:0]      o_mount_slot
);

    // a pending result stays until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("result dropped before accept");

    // a waiting request keeps its payload
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_ready |=> i_req_valid && $stable(i_operation)
            && $stable(i_client_badge) && $stable(i_cap_value))
        else $error("request changed before accept");

    // failure reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_success |-> o_mount_slot == '0)
        else $error("failed result with nonzero slot");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while busy");

    // the row walk lies between accept and a new result
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !$rose(o_rsp_valid))
        else $error("result appeared right after accept");

endmodule

bind client_capability_slot_table_core ccst_checker u_ccst_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the client capability slot table. Requests go in
// over a valid/ready channel with random gaps; results come back under random
// back-pressure. A scoreboard keeps its own copy of the client rows and slot
// store, predicts each answer when a request is accepted, and compares every
// returned item with the oldest prediction.
// ----------------------------------------------------------------------------
import ccst_pkg::*;

class ccst_scoreboard #(int ROWS = 8, int SLOTS = 16);

    typedef struct packed {
        logic               success;
        logic [MOUNT_W-1:0] slot;
    } t_mount_answer;

    // mirror of the table contents
    bit                 row_used  [ROWS];
    logic [BADGE_W-1:0] row_owner [ROWS];
    int                 row_fill  [ROWS];
    logic [CAP_W-1:0]   slot_caps [ROWS*SLOTS];

    t_mount_answer answer_q[$];

    int error_count;
    int answers_seen;
    int slots_assigned;
    int lookup_hits;
    int row_full_rejects;
    int no_row_rejects;

    // predict the answer to an accepted request and update the mirror
    function void note_request(logic op, logic [BADGE_W-1:0] badge,
                               logic [CAP_W-1:0] cap);
        int row;
        int fill;
        t_mount_answer ans;
        row = -1;
        ans = '0;
        for (int r = 0; r < ROWS; r++)
            if (row < 0 && row_used[r] && row_owner[r] == badge)
                row = r;
        if (op == OP_SET) begin
            // new client claims the lowest free row
            if (row < 0) begin
                for (int r = 0; r < ROWS; r++)
                    if (row < 0 && !row_used[r])
                        row = r;
                if (row >= 0) begin
                    row_used[row]  = 1'b1;
                    row_owner[row] = badge;
                    row_fill[row]  = 0;
                end else begin
                    no_row_rejects++;
                end
            end
            if (row >= 0) begin
                fill = row_fill[row];
                if (fill >= SLOTS) begin
                    row_full_rejects++;
                end else begin
                    slot_caps[row*SLOTS + fill] = cap;
                    row_fill[row] = fill + 1;
                    ans.success = 1'b1;
                    ans.slot = MOUNT_W'(fill);
                    slots_assigned++;
                end
            end
        end else if (row >= 0) begin
            // lowest matching slot wins
            for (int s = 0; s < row_fill[row]; s++)
                if (!ans.success && slot_caps[row*SLOTS + s] == cap) begin
                    ans.success = 1'b1;
                    ans.slot = MOUNT_W'(s);
                end
            if (ans.success)
                lookup_hits++;
        end
        answer_q.push_back(ans);
    endfunction

    // compare a returned item with the oldest prediction
    function void check_result(logic success, logic [MOUNT_W-1:0] slot);
        t_mount_answer ans;
        if (answer_q.size() == 0) begin
            $error("result with nothing pending: success=%0d mount_slot=%0d",
                   success, slot);
            error_count++;
            return;
        end
        ans = answer_q.pop_front();
        answers_seen++;
        if (success !== ans.success) begin
            $error("success: expected %0d, actual %0d", ans.success, success);
            error_count++;
        end
        if (slot !== ans.slot) begin
            $error("mount_slot: expected %0d, actual %0d", ans.slot, slot);
            error_count++;
        end
    endfunction

    function int pending();
        return answer_q.size();
    endfunction

endclass

module tb_top;

    localparam int TABLE_ROWS    = 8;
    localparam int ROW_SLOTS     = 16;
    localparam int RANDOM_ITEMS  = 626;
    localparam int CALM_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 40;
    localparam int TAIL_CYCLES   = 40;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int POOL_SIZE     = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_req_valid;
    logic                   o_req_ready;
    logic                   i_operation;
    logic [BADGE_W-1:0]     i_client_badge;
    logic signed [CAP_W-1:0] i_cap_value;
    logic                   o_rsp_valid;
    logic                   i_rsp_ready;
    logic                   o_success;
    logic [MOUNT_W-1:0]     o_mount_slot;

    ccst_scoreboard #(TABLE_ROWS, ROW_SLOTS) sb;

    logic [CAP_W-1:0] known_caps[$];
    bit               calm_tail;
    int               stalled_cycles = 0;

    client_capability_slot_table_core #(
        .MAX_CLIENTS      (TABLE_ROWS),
        .SLOTS_PER_CLIENT (ROW_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_operation    (i_operation),
        .i_client_badge (i_client_badge),
        .i_cap_value    (i_cap_value),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_success      (o_success),
        .o_mount_slot   (o_mount_slot)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // offer one request, optionally after an idle burst, and wait for accept
    task automatic send_request(input logic op, input logic [BADGE_W-1:0] badge,
                                input logic [CAP_W-1:0] cap);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_req_valid    <= 1'b1;
        i_operation    <= op;
        i_client_badge <= badge;
        i_cap_value    <= cap;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(op, badge, cap);
        if (op == OP_SET)
            known_caps.push_back(cap);
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        bit hold_done;
        int stall_left;
        hold_done  = 1'b0;
        stall_left = 0;
        i_rsp_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_rsp_valid && i_rsp_ready)
                sb.check_result(o_success, o_mount_slot);
            if (!hold_done && sb.answers_seen >= HOLD_AFTER) begin
                // long hold-off so the request side backs up
                hold_done = 1'b1;
                i_rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_req_valid && o_req_ready)
                || (o_rsp_valid && i_rsp_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_MAX) begin
            $display("[client_capability_slot_table_core] ERROR");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // reset, directed requests, random requests, drain
    initial begin
        logic [BADGE_W-1:0] badge_pool[POOL_SIZE];
        logic [BADGE_W-1:0] b;
        logic [CAP_W-1:0]   c;
        logic               op;
        sb = new();
        calm_tail      = 1'b0;
        i_rst_n        = 1'b0;
        i_req_valid    = 1'b0;
        i_operation    = OP_SET;
        i_client_badge = '0;
        i_cap_value    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // get from a client that has no row
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // fill one row to the end, extremes and a duplicate first, then overflow
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        repeat (ROW_SLOTS - 4) send_request(OP_SET, 32'hFFFF_FFFF, $urandom);
        // duplicate resolves to the lowest slot, then a miss and a mid-row hit
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // second client lands in the next free row
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        // capability held only by another client
        send_request(OP_GET, 32'h0000_0000, 32'h7FFF_FFFF);

        // random traffic over a small client pool, more clients than rows
        badge_pool[0] = 32'hFFFF_FFFF;
        badge_pool[1] = 32'h0000_0000;
        for (int k = 2; k < POOL_SIZE; k++)
            badge_pool[k] = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
            op = $urandom_range(0, 1) ? OP_GET : OP_SET;
            if ($urandom_range(0, 9) == 0)
                b = $urandom;
            else
                b = badge_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < ((op == OP_GET) ? 60 : 25))
                c = known_caps[$urandom_range(0, known_caps.size() - 1)];
            else
                c = $urandom;
            send_request(op, b, c);
        end
        i_req_valid <= 1'b0;

        // drain, then let any stray result show up
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d answers: %0d slots assigned, %0d lookups found",
                 sb.answers_seen, sb.slots_assigned, sb.lookup_hits);
        $display("rejected sets: %0d on a full row, %0d with no row left",
                 sb.row_full_rejects, sb.no_row_rejects);
        if (sb.error_count == 0)
            $display("[client_capability_slot_table_core] OK");
        else
            $display("[client_capability_slot_table_core] ERROR");
        $finish;
    end

endmodule
